### rtl/dqd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dqd_pkg
// Shared constants, operation and status codes and the ring index helper
// for the double-ended queue with delete.
// ---------------------------------------------------------------------------
package dqd_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W   = 3;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

   // ring position that lies offs places behind base
   function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/double_ended_queue_with_delete_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// double_ended_queue_with_delete_top
// Bounded deque of 32-bit words in a ring memory, with push and pop at both
// ends and delete of the first matching word.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: req_valid/req_stall carry an operation and a word. A
//    transfer happens when req_valid is high and req_stall is low. The block
//    works on one request at a time and holds req_stall high from the
//    transfer until the result has moved into the output register.
//  - rsp channel: one result per request, held in an output register until
//    the receiver takes it (rsp_valid high, rsp_stall low). While a stalled
//    result sits there, the next result waits in the final state and no new
//    request is taken.
//  - a request ends by reading the front and back words, which is skipped
//    when the queue ends up empty. A delete scans the entries from the front
//    for the first match in read and compare steps, then shifts the tail one
//    entry toward the front in read and write steps. The single memory read
//    port serves the pop data, the scan, the shift and the front and back
//    reads.
//  - next request: taken in the cycle after the result moves to the output
//    register.
//  - reset empties the queue (count and front index cleared); the memory
//    content is not cleared and no entry is readable until pushed.
// ---------------------------------------------------------------------------
module double_ended_queue_with_delete_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dqd_pkg::OP_W-1:0]      req_operation,
   input  wire logic [dqd_pkg::WORD_W-1:0]    req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [dqd_pkg::STAT_W-1:0]         rsp_status,
   output logic [dqd_pkg::WORD_W-1:0]         rsp_popped,
   output logic [dqd_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic [dqd_pkg::WORD_W-1:0]         rsp_front_word,
   output logic [dqd_pkg::WORD_W-1:0]         rsp_back_word
);

   localparam int IDX_W  = dqd_pkg::IDX_W;
   localparam int CNT_W  = dqd_pkg::CNT_W;
   localparam int WORD_W = dqd_pkg::WORD_W;
   localparam int OCC_W  = dqd_pkg::OCC_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_POP_WAIT = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CMP = 4'd4;
   localparam logic [3:0] S_SHIFT_RD = 4'd5;
   localparam logic [3:0] S_SHIFT_WR = 4'd6;
   localparam logic [3:0] S_RD_FRONT = 4'd7;
   localparam logic [3:0] S_RD_BACK  = 4'd8;
   localparam logic [3:0] S_RD_WAIT  = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0]                       state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [IDX_W-1:0]                 front_ff, front_in;
   logic [CNT_W-1:0]                 pos_ff, pos_in;
   logic [dqd_pkg::OP_W-1:0]         op_ff, op_in;
   logic [WORD_W-1:0]                val_ff, val_in;
   logic [dqd_pkg::STAT_W-1:0]       status_ff, status_in;
   logic [WORD_W-1:0]                popped_ff, popped_in;
   logic [WORD_W-1:0]                front_word_ff, front_word_in;
   logic [WORD_W-1:0]                back_word_ff, back_word_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dqd_pkg::STAT_W-1:0]       rsp_status_ff;
   logic [WORD_W-1:0]                rsp_popped_ff;
   logic [OCC_W-1:0]                 rsp_occupancy_ff;
   logic [WORD_W-1:0]                rsp_front_word_ff;
   logic [WORD_W-1:0]                rsp_back_word_ff;
   logic                             rsp_load;

   logic [WORD_W-1:0]                entry_store_ff [dqd_pkg::QUEUE_DEPTH];
   logic [WORD_W-1:0]                rd_data_ff;
   logic [IDX_W-1:0]                 rd_addr;
   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [WORD_W-1:0]                wr_data;

   logic [IDX_W-1:0]                 slot_off;
   logic [IDX_W-1:0]                 slot_idx;
   logic [IDX_W-1:0]                 front_dec;
   logic [CNT_W-1:0]                 cnt_m1;
   logic [CNT_W-1:0]                 pos_p1;
   logic                             is_full;
   logic                             is_empty;
   logic [CNT_W+OCC_W-1:0]           occ_ext;

   assign cnt_m1    = count_ff - 1'b1;
   assign pos_p1    = pos_ff + 1'b1;
   assign is_full   = (count_ff >= dqd_pkg::DEPTH_CNT);
   assign is_empty  = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? dqd_pkg::LAST_IDX : front_ff - 1'b1;
   assign occ_ext   = {{OCC_W{1'b0}}, count_ff};

   // offset into the ring for the shared slot adder
   always_comb begin
      slot_off = '0;
      unique case (state_ff)
         S_EXEC: begin
            if (op_ff == dqd_pkg::OP_PUSH_BACK) begin
               slot_off = count_ff[IDX_W-1:0];
            end else if (op_ff == dqd_pkg::OP_POP_BACK) begin
               slot_off = cnt_m1[IDX_W-1:0];
            end
         end
         S_POP_WAIT: begin
            if (op_ff == dqd_pkg::OP_POP_FRONT) begin
               slot_off = IDX_W'(1);
            end
         end
         S_SCAN_RD,
         S_SHIFT_WR: slot_off = pos_ff[IDX_W-1:0];
         S_SHIFT_RD: slot_off = pos_p1[IDX_W-1:0];
         S_RD_BACK:  slot_off = cnt_m1[IDX_W-1:0];
         default:    slot_off = '0;
      endcase
   end

   assign slot_idx = dqd_pkg::ring_slot(front_ff, slot_off);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_idx;
      wr_data       = val_ff;
      rd_addr       = slot_idx;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               val_in    = req_value;
               status_in = dqd_pkg::ST_DONE;
               popped_in = '0;
               pos_in    = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RD_FRONT;
            unique case (op_ff) inside
               dqd_pkg::OP_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = dqd_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               dqd_pkg::OP_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = dqd_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = front_dec;
                     front_in = front_dec;
                     count_in = count_ff + 1'b1;
                  end
               end
               dqd_pkg::OP_POP_FRONT, dqd_pkg::OP_POP_BACK: begin
                  if (is_empty) begin
                     status_in = dqd_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_POP_WAIT;
                  end
               end
               dqd_pkg::OP_DELETE: begin
                  if (is_empty) begin
                     status_in = dqd_pkg::ST_NOT_FOUND;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: state_in = S_RD_FRONT;
            endcase
         end
         S_POP_WAIT: begin
            popped_in = rd_data_ff;
            count_in  = cnt_m1;
            if (op_ff == dqd_pkg::OP_POP_FRONT) begin
               front_in = slot_idx;
            end
            state_in = S_RD_FRONT;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (rd_data_ff == val_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               pos_in = pos_p1;
               if (pos_p1 == count_ff) begin
                  status_in = dqd_pkg::ST_NOT_FOUND;
                  state_in  = S_RD_FRONT;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            // move the next entry one place toward the front
            if (pos_p1 < count_ff) begin
               state_in = S_SHIFT_WR;
            end else begin
               count_in = cnt_m1;
               state_in = S_RD_FRONT;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            pos_in   = pos_p1;
            state_in = S_SHIFT_RD;
         end
         S_RD_FRONT: begin
            if (is_empty) begin
               front_word_in = '0;
               back_word_in  = '0;
               state_in      = S_DONE;
            end else begin
               state_in = S_RD_BACK;
            end
         end
         S_RD_BACK: begin
            front_word_in = rd_data_ff;
            state_in      = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            back_word_in = rd_data_ff;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      if (rsp_load) begin
         rsp_status_ff     <= status_ff;
         rsp_popped_ff     <= popped_ff;
         rsp_occupancy_ff  <= occ_ext[OCC_W-1:0];
         rsp_front_word_ff <= front_word_ff;
         rsp_back_word_ff  <= back_word_ff;
      end
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_popped     = rsp_popped_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_front_word = rsp_front_word_ff;
   assign rsp_back_word  = rsp_back_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dqd_pkg::DEPTH_CNT)
      else $error("entry count beyond queue depth");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result overwritten while output stalled");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == dqd_pkg::ST_FULL)
      |-> (count_ff == dqd_pkg::DEPTH_CNT))
      else $error("full status with room left");

   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && count_ff == '0)
      |-> (front_word_ff == '0 && back_word_ff == '0))
      else $error("empty queue reports nonzero end words");

endmodule
`default_nettype wire

### verif/dqd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqd_checker
// Watches the request and result channels of the double-ended queue, keeps
// a shadow copy of the queue, predicts one result per request transfer and
// compares every result transfer, field by field, with the oldest
// prediction.
// ---------------------------------------------------------------------------
module dqd_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [dqd_pkg::OP_W-1:0]   req_operation,
   input  wire logic [dqd_pkg::WORD_W-1:0] req_value,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [dqd_pkg::STAT_W-1:0] rsp_status,
   input  wire logic [dqd_pkg::WORD_W-1:0] rsp_popped,
   input  wire logic [dqd_pkg::OCC_W-1:0]  rsp_occupancy,
   input  wire logic [dqd_pkg::WORD_W-1:0] rsp_front_word,
   input  wire logic [dqd_pkg::WORD_W-1:0] rsp_back_word,
   output int                              fail_count,
   output int                              pending,
   output int                              results_checked,
   output int                              deletes_done,
   output int                              missed_deletes,
   output int                              refused_pushes,
   output int                              empty_pops
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [dqd_pkg::STAT_W-1:0] status;
      logic [dqd_pkg::WORD_W-1:0] popped;
      logic [dqd_pkg::OCC_W-1:0]  occupancy;
      logic [dqd_pkg::WORD_W-1:0] front_word;
      logic [dqd_pkg::WORD_W-1:0] back_word;
   } deque_result_type;

   logic [dqd_pkg::WORD_W-1:0] shadow_words[$];   // front at index 0
   deque_result_type           awaited_results[$];

   int n_fail, n_checked, n_deleted, n_missed, n_refused, n_empty;

   // applies one operation to the shadow queue and returns what it reports
   function automatic deque_result_type next_deque_result(
      input logic [dqd_pkg::OP_W-1:0]   op,
      input logic [dqd_pkg::WORD_W-1:0] word);
      deque_result_type r;
      int               hit;
      r   = '0;
      hit = -1;
      case (op)
         dqd_pkg::OP_PUSH_BACK: begin
            if (shadow_words.size() >= dqd_pkg::QUEUE_DEPTH) r.status = dqd_pkg::ST_FULL;
            else shadow_words.insert(shadow_words.size(), word);
         end
         dqd_pkg::OP_PUSH_FRONT: begin
            if (shadow_words.size() >= dqd_pkg::QUEUE_DEPTH) r.status = dqd_pkg::ST_FULL;
            else shadow_words.insert(0, word);
         end
         dqd_pkg::OP_POP_FRONT: begin
            if (shadow_words.size() == 0) r.status = dqd_pkg::ST_EMPTY;
            else begin
               r.popped = shadow_words[0];
               shadow_words.delete(0);
            end
         end
         dqd_pkg::OP_POP_BACK: begin
            if (shadow_words.size() == 0) r.status = dqd_pkg::ST_EMPTY;
            else begin
               r.popped = shadow_words[shadow_words.size() - 1];
               shadow_words.delete(shadow_words.size() - 1);
            end
         end
         dqd_pkg::OP_DELETE: begin
            // only the match nearest the front goes, the tail closes up
            for (int i = 0; i < shadow_words.size() && hit < 0; i++) begin
               if (shadow_words[i] == word) hit = i;
            end
            if (hit < 0) r.status = dqd_pkg::ST_NOT_FOUND;
            else shadow_words.delete(hit);
         end
         default: ;
      endcase
      r.occupancy = dqd_pkg::OCC_W'(shadow_words.size());
      if (shadow_words.size() != 0) begin
         r.front_word = shadow_words[0];
         r.back_word  = shadow_words[shadow_words.size() - 1];
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      deque_result_type want;
      deque_result_type got;
      if (reset) begin
         shadow_words.delete();
         awaited_results.delete();
      end else begin
         // a result never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_popped, rsp_occupancy, rsp_front_word, rsp_back_word};
            if (awaited_results.size() == 0) begin
               n_fail++;
               if (n_fail <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result transfer status=%0d popped=%h occ=%0d",
                           $realtime, got.status, got.popped, got.occupancy);
               end
            end else begin
               want = awaited_results[0];
               awaited_results.delete(0);
               n_checked++;
               if (got !== want) begin
                  n_fail++;
                  if (n_fail <= REPORT_LIMIT) begin
                     $display("%0t: result %0d mismatch", $realtime, n_checked);
                     $display("   expected status=%0d popped=%h occ=%0d front=%h back=%h",
                              want.status, want.popped, want.occupancy,
                              want.front_word, want.back_word);
                     $display("   actual   status=%0d popped=%h occ=%0d front=%h back=%h",
                              got.status, got.popped, got.occupancy,
                              got.front_word, got.back_word);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = next_deque_result(req_operation, req_value);
            awaited_results.insert(awaited_results.size(), want);
            case (want.status)
               dqd_pkg::ST_FULL:      n_refused++;
               dqd_pkg::ST_EMPTY:     n_empty++;
               dqd_pkg::ST_NOT_FOUND: n_missed++;
               default:      if (req_operation == dqd_pkg::OP_DELETE) n_deleted++;
            endcase
         end
      end
      fail_count      <= n_fail;
      pending         <= awaited_results.size();
      results_checked <= n_checked;
      deletes_done    <= n_deleted;
      missed_deletes  <= n_missed;
      refused_pushes  <= n_refused;
      empty_pops      <= n_empty;
   end

endmodule

### verif/double_ended_queue_with_delete_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_queue_with_delete_top_test
// Drives directed corner requests and then biased random request streams
// into the deque, with bursty requests and a stalling receiver, and reports
// the verdict from the checker's failure and pending counts.
// ---------------------------------------------------------------------------
module double_ended_queue_with_delete_top_test;

   localparam int RANDOM_COUNT = 1520;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 4 * dqd_pkg::QUEUE_DEPTH + 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int POOL_SIZE    = 8;

   typedef enum int {FILL_BIAS, DRAIN_BIAS, MIXED_BIAS} traffic_bias_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [dqd_pkg::OP_W-1:0]     req_operation;
   logic [dqd_pkg::WORD_W-1:0]   req_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [dqd_pkg::STAT_W-1:0]   rsp_status;
   logic [dqd_pkg::WORD_W-1:0]   rsp_popped;
   logic [dqd_pkg::OCC_W-1:0]    rsp_occupancy;
   logic [dqd_pkg::WORD_W-1:0]   rsp_front_word;
   logic [dqd_pkg::WORD_W-1:0]   rsp_back_word;

   int fail_count, pending, results_checked;
   int deletes_done, missed_deletes, refused_pushes, empty_pops;
   int sent_count;
   int idle_cycles;

   logic [dqd_pkg::WORD_W-1:0] word_pool[POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   double_ended_queue_with_delete_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_popped     (rsp_popped),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_front_word (rsp_front_word),
      .rsp_back_word  (rsp_back_word)
   );

   dqd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_popped      (rsp_popped),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_front_word  (rsp_front_word),
      .rsp_back_word   (rsp_back_word),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .deletes_done    (deletes_done),
      .missed_deletes  (missed_deletes),
      .refused_pushes  (refused_pushes),
      .empty_pops      (empty_pops)
   );

   // holds the request until it transfers
   task automatic offer_request(input logic [dqd_pkg::OP_W-1:0]   op,
                                input logic [dqd_pkg::WORD_W-1:0] word);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= word;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [dqd_pkg::OP_W-1:0] pick_operation(input traffic_bias_type bias);
      int roll;
      int push_pct;
      int pop_pct;
      roll     = $urandom_range(0, 99);
      push_pct = (bias == FILL_BIAS) ? 60 : (bias == DRAIN_BIAS) ? 20 : 42;
      pop_pct  = (bias == FILL_BIAS) ? 20 : (bias == DRAIN_BIAS) ? 60 : 38;
      if (roll < 3) begin
         return dqd_pkg::OP_W'($urandom_range(int'(dqd_pkg::OP_DELETE) + 1,
                                              (1 << dqd_pkg::OP_W) - 1));
      end else if (roll < 3 + push_pct) begin
         return $urandom_range(0, 1) ? dqd_pkg::OP_PUSH_FRONT : dqd_pkg::OP_PUSH_BACK;
      end else if (roll < 3 + push_pct + pop_pct) begin
         return $urandom_range(0, 1) ? dqd_pkg::OP_POP_FRONT : dqd_pkg::OP_POP_BACK;
      end
      return dqd_pkg::OP_DELETE;
   endfunction

   // mostly words from a small pool so that deletes find duplicates
   function automatic logic [dqd_pkg::WORD_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 9) return $urandom;
      return $urandom_range(0, 1) ? '1 : '0;
   endfunction

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  IDLE_LIMIT, pending);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, with long hold-offs that back the block up
   initial begin : receiver
      stall_mode_type mode;
      int             span;
      int             seen;
      int             next_hold;
      rsp_stall <= 1'b0;
      seen      = 0;
      next_hold = $urandom_range(300, 500);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 120);
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            if (!reset && req_valid && !req_stall) seen++;
            if (seen >= next_hold) begin
               next_hold = seen + $urandom_range(500, 700);
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               case (mode)
                  STALL_NONE:     rsp_stall <= 1'b0;
                  STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                  STALL_PERIODIC: rsp_stall <= (k % 3 == 0);
                  default:        rsp_stall <= 1'b0;
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      logic [dqd_pkg::WORD_W-1:0] corner_words[4];
      traffic_bias_type           bias;
      int                         burst;
      int                         gap;
      int                         n;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= dqd_pkg::OP_PUSH_BACK;
      req_value     <= '0;
      sent_count    = 0;
      corner_words  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE};
      word_pool[0]  = '0;
      word_pool[1]  = '1;
      for (int i = 2; i < POOL_SIZE; i++) word_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue: both pops and a delete are refused, then each unused code is sent
      offer_request(dqd_pkg::OP_POP_FRONT, '0);
      offer_request(dqd_pkg::OP_POP_BACK, '1);
      offer_request(dqd_pkg::OP_DELETE, '0);
      for (int c = int'(dqd_pkg::OP_DELETE) + 1; c < (1 << dqd_pkg::OP_W); c++) begin
         offer_request(dqd_pkg::OP_W'(c), $urandom);
      end
      // fill from both ends with repeated words, then push into a full queue
      for (int i = 0; i < dqd_pkg::QUEUE_DEPTH; i++) begin
         offer_request(i[0] ? dqd_pkg::OP_PUSH_FRONT : dqd_pkg::OP_PUSH_BACK,
                       corner_words[i % 4]);
      end
      offer_request(dqd_pkg::OP_PUSH_BACK, 32'h1234_5678);
      offer_request(dqd_pkg::OP_PUSH_FRONT, 32'h8765_4321);
      offer_request(dqd_pkg::OP_DELETE, '1);
      offer_request(dqd_pkg::OP_DELETE, 32'hDEAD_BEEF);
      offer_request(dqd_pkg::OP_POP_FRONT, '0);
      offer_request(dqd_pkg::OP_POP_BACK, '0);

      n    = 0;
      bias = MIXED_BIAS;
      while (n < RANDOM_COUNT) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && n < RANDOM_COUNT; k++) begin
            if (n % 64 == 0) bias = traffic_bias_type'($urandom_range(0, 2));
            offer_request(pick_operation(bias), pick_word());
            n++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         idle_sender(gap);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests, checked %0d results", sent_count, results_checked);
      $display("deletes %0d hit / %0d missed, %0d pushes refused as full, %0d empty pops",
               deletes_done, missed_deletes, refused_pushes, empty_pops);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### double_ended_queue_with_delete_top.f
rtl/dqd_pkg.sv
rtl/double_ended_queue_with_delete_top.sv
verif/dqd_checker.sv
verif/double_ended_queue_with_delete_top_test.sv
